>>> rtl/lra_pkg.sv
package lra_pkg;

	localparam int LABEL_W      = 4;
	localparam int LABEL_SLOTS  = 1 << LABEL_W;
	localparam int DIM_W        = 11;
	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_LIMIT = 1024;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int NB_COUNT     = 4;
	localparam int NB_IDX_W     = $clog2(NB_COUNT);
	localparam int FIFO_AW      = 4;
	localparam int FIFO_DEPTH   = 1 << FIFO_AW;
	localparam int REG_IDX_W    = 2;

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [COL_W-1:0]   col_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [DIM_W-1:0]   dim_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} reg_idx_t;

	// neighbor order: west, north-west, north, north-east
	typedef struct packed {
		label_t                    cur;
		label_t [NB_COUNT-1:0]     nb;
		logic   [NB_COUNT-1:0]     mask;
	} pair_rec_t;

	// last valid position for a dimension register; zero counts as one
	function automatic logic [COL_W-1:0] dim_last(input dim_t v, input dim_t lim);
		dim_t d;
		begin
			if (v == '0) begin
				d = '0;
			end else if (v > lim) begin
				d = lim - dim_t'(1);
			end else begin
				d = v - dim_t'(1);
			end
			dim_last = d[COL_W-1:0];
		end
	endfunction

endpackage

>>> rtl/lra_pixel_if.sv
interface lra_pixel_if;
	logic             valid;
	logic             ready;
	lra_pkg::label_t  label;

	modport source (output valid, output label, input ready);
	modport sink   (input valid, input label, output ready);
endinterface

>>> rtl/lra_pair_if.sv
interface lra_pair_if;
	logic             valid;
	logic             ready;
	lra_pkg::label_t  region;
	lra_pkg::label_t  neighbor;
	logic             last;

	modport source (output valid, output region, output neighbor, output last, input ready);
	modport sink   (input valid, input region, input neighbor, input last, output ready);
endinterface

>>> rtl/lra_ram.sv
module lra_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lra_pair_queue.sv
module lra_pair_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lra_pkg::pair_rec_t  push_rec,
	output logic                full,
	lra_pair_if.source          pairs
);

	lra_pkg::pair_rec_t                      fifo_q [lra_pkg::FIFO_DEPTH];
	logic [lra_pkg::FIFO_AW-1:0]             wr_ptr_q;
	logic [lra_pkg::FIFO_AW-1:0]             rd_ptr_q;
	logic [lra_pkg::FIFO_AW:0]               count_q;

	logic                                    ser_valid_q;
	logic                                    ser_phase_q;
	lra_pkg::label_t                         ser_cur_q;
	lra_pkg::label_t [lra_pkg::NB_COUNT-1:0] ser_nb_q;
	logic [lra_pkg::NB_COUNT-1:0]            ser_mask_q;

	logic [lra_pkg::NB_IDX_W-1:0]            sel_k;
	logic [lra_pkg::NB_COUNT-1:0]            rest_mask;
	logic                                    advance;
	logic                                    done;
	logic                                    load;
	logic                                    pop;

	assign full = (count_q == (lra_pkg::FIFO_AW+1)'(lra_pkg::FIFO_DEPTH));

	// lowest pending neighbor goes first
	always_comb begin
		sel_k = '0;
		for (int k = lra_pkg::NB_COUNT - 1; k >= 0; k--) begin
			if (ser_mask_q[k]) begin
				sel_k = lra_pkg::NB_IDX_W'(k);
			end
		end
	end

	assign rest_mask = ser_mask_q & ~(lra_pkg::NB_COUNT'(1) << sel_k);
	assign advance   = ser_valid_q && pairs.ready;
	assign done      = advance && ser_phase_q && (rest_mask == '0);
	assign load      = (count_q != '0) && (!ser_valid_q || done);
	assign pop       = load;

	assign pairs.valid    = ser_valid_q;
	assign pairs.region   = ser_phase_q ? ser_nb_q[sel_k] : ser_cur_q;
	assign pairs.neighbor = ser_phase_q ? ser_cur_q : ser_nb_q[sel_k];
	assign pairs.last     = ser_phase_q && (rest_mask == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			ser_phase_q <= 1'b0;
		end else if (load) begin
			ser_valid_q <= 1'b1;
			ser_phase_q <= 1'b0;
		end else if (done) begin
			ser_valid_q <= 1'b0;
			ser_phase_q <= 1'b0;
		end else if (advance) begin
			ser_phase_q <= !ser_phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ser_cur_q  <= fifo_q[rd_ptr_q].cur;
			ser_nb_q   <= fifo_q[rd_ptr_q].nb;
			ser_mask_q <= fifo_q[rd_ptr_q].mask;
		end else if (advance && ser_phase_q) begin
			ser_mask_q <= rest_mask;
		end
	end

endmodule

>>> rtl/label_region_adjacency_unit.sv
// one pixel accepted per cycle unless the input is held; the row store is read and written at acceptance
// a pixel's pairs pass through the stage 1 registers, the queue and the serializer registers
// pairs leave one per cycle while the sink is ready, from a queue of 16 pixel records
// a pixel with new pairs holds the input while the queue is full
// reset clears position, window, adjacency matrix, queue and registers (640 x 480)
// the row store is not cleared; it is rewritten as each row streams in
module label_region_adjacency_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [lra_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [lra_pkg::DIM_W-1:0]       cfg_data,
	lra_pixel_if.sink                       pixels,
	lra_pair_if.source                      pairs
);

	lra_pkg::col_t                                      w_last_q;
	lra_pkg::row_t                                      h_last_q;
	lra_pkg::col_t                                      col_q;
	lra_pkg::row_t                                      row_q;

	logic                                               accept;
	logic                                               row_end;
	logic                                               frame_end;
	lra_pkg::col_t                                      addr_ne;

	logic                                               valid_s1;
	lra_pkg::label_t                                    cur_s1;
	logic                                               has_w_s1;
	logic                                               row_nz_s1;
	logic                                               has_n_s1;
	logic                                               has_ne_s1;
	logic                                               frame_end_s1;

	lra_pkg::label_t                                    rd_n;
	lra_pkg::label_t                                    rd_ne;
	lra_pkg::label_t                                    win_w_q;
	lra_pkg::label_t                                    win_n_q;

	logic [lra_pkg::LABEL_SLOTS-1:0][lra_pkg::LABEL_SLOTS-1:0] adj_q;
	logic [lra_pkg::LABEL_SLOTS-1:0][lra_pkg::LABEL_SLOTS-1:0] adj_d;

	lra_pkg::label_t [lra_pkg::NB_COUNT-1:0]            nb;
	logic [lra_pkg::NB_COUNT-1:0]                       ok;
	logic [lra_pkg::NB_COUNT-1:0]                       cand;
	logic [lra_pkg::NB_COUNT-1:0]                       new_mask;
	logic [lra_pkg::LABEL_SLOTS-1:0]                    cur_row;
	logic                                               has_new;
	logic                                               s1_fire;
	logic                                               q_push;
	logic                                               q_full;
	lra_pkg::pair_rec_t                                 q_rec;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= lra_pkg::COL_W'(lra_pkg::WIDTH_RESET - 1);
			h_last_q <= lra_pkg::ROW_W'(lra_pkg::HEIGHT_RESET - 1);
		end else if (cfg_write_en) begin
			unique case (lra_pkg::reg_idx_t'(cfg_index))
				lra_pkg::REG_IMAGE_WIDTH: begin
					w_last_q <= lra_pkg::dim_last(cfg_data,
						lra_pkg::DIM_W'(lra_pkg::MAX_WIDTH));
				end
				lra_pkg::REG_IMAGE_HEIGHT: begin
					h_last_q <= lra_pkg::ROW_W'(lra_pkg::dim_last(cfg_data,
						lra_pkg::DIM_W'(lra_pkg::HEIGHT_LIMIT)));
				end
				default: begin
				end
			endcase
		end
	end

	// position
	assign accept    = pixels.valid && pixels.ready;
	assign row_end   = (col_q >= w_last_q);
	assign frame_end = row_end && (row_q >= h_last_q);
	assign addr_ne   = col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// previous row, one copy per read port
	lra_ram #(
		.WIDTH (lra_pkg::LABEL_W),
		.DEPTH (lra_pkg::MAX_WIDTH)
	) u_row_n (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (pixels.label),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_n)
	);

	lra_ram #(
		.WIDTH (lra_pkg::LABEL_W),
		.DEPTH (lra_pkg::MAX_WIDTH)
	) u_row_ne (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (pixels.label),
		.re    (accept),
		.raddr (addr_ne),
		.rdata (rd_ne)
	);

	// stage 1 request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1       <= pixels.label;
			has_w_s1     <= (col_q != '0);
			row_nz_s1    <= (row_q != '0);
			has_n_s1     <= (row_q != '0) && (col_q <= w_last_q);
			has_ne_s1    <= (row_q != '0) && (col_q < w_last_q);
			frame_end_s1 <= frame_end;
		end
	end

	assign nb[0] = win_w_q;
	assign nb[1] = win_n_q;
	assign nb[2] = has_n_s1 ? rd_n : '0;
	assign nb[3] = has_ne_s1 ? rd_ne : '0;
	assign ok    = {has_ne_s1, has_n_s1, has_w_s1 && row_nz_s1, has_w_s1};

	assign cur_row = adj_q[cur_s1];

	// a label repeated among earlier neighbors is already covered
	always_comb begin
		for (int k = 0; k < lra_pkg::NB_COUNT; k++) begin
			cand[k] = ok[k] && (nb[k] != '0) && (nb[k] != cur_s1) && (cur_s1 != '0);
		end
		for (int k = 0; k < lra_pkg::NB_COUNT; k++) begin
			new_mask[k] = cand[k] && !cur_row[nb[k]];
			for (int j = 0; j < k; j++) begin
				if (cand[j] && (nb[j] == nb[k])) begin
					new_mask[k] = 1'b0;
				end
			end
		end
	end

	assign has_new = (new_mask != '0);
	assign s1_fire = valid_s1 && (!has_new || !q_full);
	assign q_push  = s1_fire && has_new;

	assign pixels.ready = !valid_s1 || s1_fire;

	always_comb begin
		adj_d = adj_q;
		for (int k = 0; k < lra_pkg::NB_COUNT; k++) begin
			if (new_mask[k]) begin
				adj_d[cur_s1][nb[k]] = 1'b1;
				adj_d[nb[k]][cur_s1] = 1'b1;
			end
		end
		if (frame_end_s1) begin
			adj_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q   <= '0;
			win_w_q <= '0;
			win_n_q <= '0;
		end else if (s1_fire) begin
			adj_q   <= adj_d;
			win_w_q <= cur_s1;
			win_n_q <= nb[2];
		end
	end

	assign q_rec.cur  = cur_s1;
	assign q_rec.nb   = nb;
	assign q_rec.mask = new_mask;

	lra_pair_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.full     (q_full),
		.pairs    (pairs)
	);

`ifndef NO_ASSERTIONS
	a_pair_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		pairs.valid |-> (pairs.region != pairs.neighbor) && (pairs.region != '0)
			&& (pairs.neighbor != '0))
		else $error("pair with equal or background labels");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && frame_end_s1) |=> (adj_q == '0))
		else $error("adjacency not cleared at frame end");

	a_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cur_s1 != '0)) |-> (adj_q[cur_s1][nb[0]] == adj_q[nb[0]][cur_s1]))
		else $error("adjacency matrix lost symmetry");
`endif

endmodule

>>> verif/region_pair_checker.sv
`timescale 1ns / 1ps

module region_pair_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [lra_pkg::REG_IDX_W-1:0] cfg_index,
	input  lra_pkg::dim_t                 cfg_data,
	lra_pixel_if                          pixels,
	lra_pair_if                           pairs,
	output int                            mismatch_count,
	output int                            pairs_outstanding
);
	import lra_pkg::*;

	localparam int REPORT_CAP = 100;

	typedef struct packed {
		label_t region;
		label_t neighbor;
		logic   last;
	} region_pair_t;

	region_pair_t           expected_pairs[$];
	region_pair_t           oldest;
	label_t                 prev_row [MAX_WIDTH];
	logic [LABEL_SLOTS-1:0] seen [LABEL_SLOTS];
	label_t                 west_label;
	label_t                 north_label;
	dim_t                   width_reg;
	dim_t                   height_reg;
	int                     col_pos;
	int                     row_pos;

	function automatic int clamp_dim(input dim_t v, input int lim);
		if (v == '0) begin
			return 1;
		end
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	task automatic clear_seen();
		for (int i = 0; i < LABEL_SLOTS; i++) begin
			seen[i] = '0;
		end
	endtask

	// neighbor order west, north-west, north, north-east; mirror pair follows each
	task automatic predict_pixel_pairs(input label_t cur);
		int           w;
		int           h;
		int           n_found;
		label_t       nb [NB_COUNT];
		logic         ok [NB_COUNT];
		region_pair_t found [2*NB_COUNT];
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, HEIGHT_LIMIT);
		ok[0] = col_pos > 0;
		ok[1] = ok[0] && row_pos > 0;
		ok[2] = row_pos > 0 && col_pos < w;
		ok[3] = row_pos > 0 && col_pos + 1 < w;
		nb[0] = west_label;
		nb[1] = north_label;
		nb[2] = ok[2] ? prev_row[col_pos] : '0;
		nb[3] = ok[3] ? prev_row[col_pos + 1] : '0;
		n_found = 0;
		if (cur != '0) begin
			for (int k = 0; k < NB_COUNT; k++) begin
				if (ok[k] && nb[k] != '0 && nb[k] != cur && !seen[cur][nb[k]]) begin
					seen[cur][nb[k]] = 1'b1;
					seen[nb[k]][cur] = 1'b1;
					found[n_found] = '{cur, nb[k], 1'b0};
					found[n_found + 1] = '{nb[k], cur, 1'b0};
					n_found += 2;
				end
			end
			if (n_found > 0) begin
				found[n_found - 1].last = 1'b1;
			end
			for (int k = 0; k < n_found; k++) begin
				expected_pairs = {expected_pairs, found[k]};
			end
		end
		west_label = cur;
		north_label = nb[2];
		if (col_pos < MAX_WIDTH) begin
			prev_row[col_pos] = cur;
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			west_label = '0;
			north_label = '0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				clear_seen();
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endtask

	task automatic report_mismatch(input string field, input label_t want_v, input label_t got_v);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = dim_t'(WIDTH_RESET);
			height_reg = dim_t'(HEIGHT_RESET);
			west_label = '0;
			north_label = '0;
			col_pos = 0;
			row_pos = 0;
			clear_seen();
			expected_pairs.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_write_en) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data;
				end else if (cfg_index == REG_IMAGE_HEIGHT) begin
					height_reg = cfg_data;
				end
			end
			if (pixels.valid && pixels.ready) begin
				predict_pixel_pairs(pixels.label);
			end
			if (pairs.valid && pairs.ready) begin
				if (expected_pairs.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_CAP) begin
						$error("unexpected pair: region %0d, neighbor %0d, last %0d",
							pairs.region, pairs.neighbor, pairs.last);
					end
				end else begin
					oldest = expected_pairs.pop_front();
					if (pairs.region !== oldest.region) begin
						report_mismatch("region", oldest.region, pairs.region);
					end
					if (pairs.neighbor !== oldest.neighbor) begin
						report_mismatch("neighbor", oldest.neighbor, pairs.neighbor);
					end
					if (pairs.last !== oldest.last) begin
						report_mismatch("last", label_t'(oldest.last), label_t'(pairs.last));
					end
				end
			end
		end
		pairs_outstanding = expected_pairs.size();
	end

endmodule

>>> verif/tb_label_region_adjacency_unit.sv
`timescale 1ns / 1ps

module tb_label_region_adjacency_unit;
	import lra_pkg::*;

	localparam int IDLE_MAX      = 8;
	localparam int DRAIN_CYCLES  = 40;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_PIXELS = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [REG_IDX_W-1:0] cfg_index;
	dim_t                 cfg_data;
	int                   mismatch_count;
	int                   pairs_outstanding;
	bit                   pixel_gaps;
	bit                   pair_stalls;
	int                   quiet_cycles = 0;

	lra_pixel_if pixel_ch ();
	lra_pair_if  pair_ch ();

	label_region_adjacency_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixels       (pixel_ch),
		.pairs        (pair_ch)
	);

	region_pair_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.pixels            (pixel_ch),
		.pairs             (pair_ch),
		.mismatch_count    (mismatch_count),
		.pairs_outstanding (pairs_outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// no request moved for too long
	always @(posedge clk) begin
		if ((pixel_ch.valid && pixel_ch.ready) || (pair_ch.valid && pair_ch.ready)
			|| cfg_write_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("label_region_adjacency_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int frame_pixels(input dim_t w, input dim_t h);
		int ew;
		int eh;
		ew = (w == '0) ? 1 : ((int'(w) > MAX_WIDTH) ? MAX_WIDTH : int'(w));
		eh = (h == '0) ? 1 : ((int'(h) > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(h));
		return ew * eh;
	endfunction

	task automatic send_pixel(input label_t v);
		int gap;
		gap = pixel_gaps ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			@(negedge clk);
			pixel_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pixel_ch.valid <= 1'b1;
		pixel_ch.label <= v;
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
	endtask

	task automatic drain_queue();
		@(negedge clk);
		pixel_ch.valid <= 1'b0;
		while (pairs_outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input dim_t v);
		drain_queue();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// whole frames; most use a small palette so regions repeat, some are noise
	task automatic run_frames(input dim_t w, input dim_t h, input int frames);
		int     total;
		bit     noisy;
		label_t palette [4];
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		pixel_gaps = $urandom_range(0, 3) != 0;
		pair_stalls = $urandom_range(0, 3) != 0;
		total = frame_pixels(w, h);
		for (int f = 0; f < frames; f++) begin
			noisy = $urandom_range(0, 3) == 0;
			foreach (palette[i]) begin
				palette[i] = label_t'($urandom_range(1, 15));
			end
			for (int p = 0; p < total; p++) begin
				if ($urandom_range(0, 39) == 0) begin
					drain_queue();
				end
				if (noisy) begin
					send_pixel(label_t'($urandom_range(0, 15)));
				end else if ($urandom_range(0, 4) == 0) begin
					send_pixel('0);
				end else begin
					send_pixel(palette[$urandom_range(0, 3)]);
				end
			end
		end
	endtask

	initial begin
		gap_pairs: begin
			int gap;
			pair_ch.ready = 1'b0;
			forever begin
				gap = pair_stalls ? $urandom_range(0, IDLE_MAX) : 0;
				if (gap > 0) begin
					@(negedge clk);
					pair_ch.ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				@(negedge clk);
				pair_ch.ready <= 1'b1;
				@(posedge clk);
				while (!pair_ch.valid) @(posedge clk);
			end
		end
	end

	initial begin
		int   random_count;
		dim_t w;
		dim_t h;
		int   frames;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		pixel_ch.valid = 1'b0;
		pixel_ch.label = '0;
		pixel_gaps = 1'b1;
		pair_stalls = 1'b1;
		random_count = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// row 0 at the reset geometry, then shrink the width mid-row
		send_pixel(4'd15); send_pixel(4'd1); send_pixel(4'd1); send_pixel(4'd0); send_pixel(4'd2);
		write_reg(REG_IMAGE_WIDTH, 11'd3);
		send_pixel(4'd3);
		send_pixel(4'd2); send_pixel(4'd4); send_pixel(4'd15);
		// second pixel sees four fresh neighbors
		send_pixel(4'd6); send_pixel(4'd5); send_pixel(4'd0);
		// zero height mid-frame ends the frame at the end of this row
		write_reg(REG_IMAGE_HEIGHT, 11'd0);
		send_pixel(4'd7); send_pixel(4'd7); send_pixel(4'd7);
		// pairs come back after the frame clears
		write_reg(REG_IMAGE_HEIGHT, 11'd1);
		send_pixel(4'd7); send_pixel(4'd6); send_pixel(4'd7);
		write_reg(REG_IMAGE_WIDTH, 11'd0);
		write_reg(REG_IMAGE_HEIGHT, 11'd2);
		send_pixel(4'd3); send_pixel(4'd9);

		// clamped extremes, cut short by shrinking the geometry mid-row
		write_reg(REG_IMAGE_WIDTH, 11'd2047);
		write_reg(REG_IMAGE_HEIGHT, 11'd2047);
		send_pixel(4'd1); send_pixel(4'd2); send_pixel(4'd2); send_pixel(4'd3);
		send_pixel(4'd0); send_pixel(4'd3);
		write_reg(REG_IMAGE_HEIGHT, 11'd1);
		write_reg(REG_IMAGE_WIDTH, 11'd2);
		send_pixel(4'd4);

		while (random_count < RANDOM_PIXELS) begin
			w = ($urandom_range(0, 9) == 0) ? dim_t'(0) : dim_t'($urandom_range(1, 8));
			h = dim_t'($urandom_range(0, 6));
			frames = $urandom_range(1, 2);
			run_frames(w, h, frames);
			random_count += frames * frame_pixels(w, h);
		end

		drain_queue();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pairs_outstanding == 0) begin
			$display("label_region_adjacency_unit regression: pass");
		end else begin
			$display("label_region_adjacency_unit regression: fail");
		end
		$finish;
	end

endmodule
